// ===== design/assert_macros.svh =====
// Assertion macros shared by the modular arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define AMU_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AMU_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/amu_pkg.sv =====
// Types, codes and helper functions of the modular arithmetic unit.
package amu_pkg;

    localparam logic [29:0] MODULUS_RESET = 30'd998244353;
    localparam logic [0:0]  REG_MODULUS   = 1'b0;

    // Last count of each serial loop (count runs down to zero).
    localparam logic [5:0] MUL_LAST = 6'd29;
    localparam logic [5:0] RED_LAST = 6'd62;
    localparam logic [5:0] DIV_LAST = 6'd29;

    typedef enum logic [2:0] {
        FN_ADD    = 3'd0,
        FN_SUB    = 3'd1,
        FN_MUL    = 3'd2,
        FN_POW    = 3'd3,
        FN_INV    = 3'd4,
        FN_DIV    = 3'd5,
        FN_NEG    = 3'd6,
        FN_REDUCE = 3'd7
    } func_t;

    // Operand pairs for the modular multiplier: x is the addend, y the scanned word.
    typedef enum logic [1:0] {
        MS_A_B     = 2'd0,
        MS_BASE_RES = 2'd1,
        MS_BASE_SQ = 2'd2,
        MS_A_INV   = 2'd3
    } mul_src_t;

    typedef enum logic {
        MD_RES  = 1'b0,
        MD_BASE = 1'b1
    } mul_dest_t;

    typedef struct packed {
        logic      load;
        logic      simple;
        logic      mul_start;
        mul_src_t  mul_src;
        mul_dest_t mul_dest;
        logic      red_start;
        logic      mul_step;
        logic      pow_init;
        logic      e_shift;
        logic      euc_init;
        logic      div_start;
        logic      div_step;
        logic      emul;
        logic      eupd;
        logic      efix;
        logic      out_load;
    } amu_cmd_t;

    typedef struct packed {
        func_t func;
        logic  err;
        logic  mod_zero;
        logic  cnt_zero;
        logic  e_zero;
        logic  e_lsb;
        logic  e_one;
        logic  ea_zero;
    } amu_sts_t;

    // One Horner step: (2*r + addend) mod m, with r and addend below m.
    function automatic logic [29:0] mod_step(input logic [29:0] r,
                                             input logic [29:0] addend,
                                             input logic [29:0] m);
        logic [30:0] t;
        logic [30:0] u;
        t = {r, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        u = t + {1'b0, addend};
        if (u >= {1'b0, m}) begin
            u = u - {1'b0, m};
        end
        return u[29:0];
    endfunction

endpackage

// ===== design/amu_datapath.sv =====
// Datapath: operand registers, serial modular multiplier/reducer, divider, Euclid state.
`include "assert_macros.svh"
module amu_datapath
    import amu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [29:0] modulus,
    input  logic [2:0]  s_func,
    input  logic [29:0] s_operand_a,
    input  logic [29:0] s_operand_b,
    input  logic [62:0] s_exponent,
    input  logic [63:0] s_raw_value,
    input  amu_cmd_t    cmd,
    output amu_sts_t    sts,
    output logic [29:0] m_result,
    output logic        m_range_error
);

    func_t        func_reg;
    logic [29:0]  a_reg, b_reg;
    logic [62:0]  e_reg;
    logic [63:0]  raw_reg;
    logic [29:0]  res_reg, base_reg;
    logic [29:0]  mx_reg, mr_reg;
    logic [63:0]  sh_reg;
    logic [5:0]   cnt_reg;
    mul_dest_t    dest_reg;
    logic [29:0]  er_reg, ea_reg, dq_reg, drem_reg;
    logic signed [31:0] eu_reg, ev_reg, prod_reg;
    logic [29:0]  out_result_reg;
    logic         out_err_reg;

    logic         uses_b, err;
    logic [29:0]  simple_val, inv_fix, mr_next, mul_x, mul_y;
    logic [30:0]  sum, div_t;
    logic signed [31:0] mod_s, fix_s;
    logic         div_ge;

    // Range check of the operands the operation reads
    always_comb begin
        uses_b = (func_reg == FN_ADD) || (func_reg == FN_SUB) ||
                 (func_reg == FN_MUL) || (func_reg == FN_DIV);
        err    = (func_reg != FN_REDUCE) &&
                 ((a_reg >= modulus) || (uses_b && (b_reg >= modulus)));
    end

    // Combinational results: add, sub, neg, and zero for errors and all other functions
    always_comb begin
        sum        = {1'b0, a_reg} + {1'b0, b_reg};
        simple_val = '0;
        if (!err) begin
            case (func_reg)
                FN_ADD: begin
                    simple_val = (sum >= {1'b0, modulus}) ?
                                 30'(sum - {1'b0, modulus}) : sum[29:0];
                end
                FN_SUB: begin
                    simple_val = (a_reg >= b_reg) ? (a_reg - b_reg) :
                                 30'({1'b0, a_reg} + {1'b0, modulus} - {1'b0, b_reg});
                end
                FN_NEG: begin
                    simple_val = (a_reg == '0) ? '0 : (modulus - a_reg);
                end
                default: simple_val = '0;
            endcase
        end
    end

    // Euclid coefficient folded into 0 .. modulus-1
    always_comb begin
        mod_s = $signed({2'b00, modulus});
        if (eu_reg < 0) begin
            fix_s = eu_reg + mod_s;
        end else if (eu_reg >= mod_s) begin
            fix_s = eu_reg - mod_s;
        end else begin
            fix_s = eu_reg;
        end
        inv_fix = fix_s[29:0];
    end

    // Multiplier operand select
    always_comb begin
        case (cmd.mul_src)
            MS_A_B:      begin mul_x = a_reg;    mul_y = b_reg;    end
            MS_BASE_RES: begin mul_x = base_reg; mul_y = res_reg;  end
            MS_BASE_SQ:  begin mul_x = base_reg; mul_y = base_reg; end
            MS_A_INV:    begin mul_x = a_reg;    mul_y = inv_fix;  end
            default:     begin mul_x = a_reg;    mul_y = b_reg;    end
        endcase
    end

    assign mr_next = mod_step(mr_reg, sh_reg[63] ? mx_reg : '0, modulus);

    // Restoring divider step
    always_comb begin
        div_t  = {drem_reg, dq_reg[29]};
        div_ge = div_t >= {1'b0, ea_reg};
    end

    // Operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(s_func);
            a_reg    <= s_operand_a;
            b_reg    <= s_operand_b;
            e_reg    <= s_exponent;
            raw_reg  <= s_raw_value;
        end else if (cmd.e_shift) begin
            e_reg    <= {1'b0, e_reg[62:1]};
        end
    end

    // Serial multiplier / reducer, divider, result and base registers
    always_ff @(posedge aclk) begin
        if (cmd.simple) begin
            res_reg <= simple_val;
        end
        if (cmd.pow_init) begin
            res_reg  <= (modulus == 30'd1) ? 30'd0 : 30'd1;
            base_reg <= a_reg;
        end
        if (cmd.efix) begin
            res_reg <= inv_fix;
        end
        if (cmd.mul_start) begin
            mx_reg   <= mul_x;
            sh_reg   <= {mul_y, 34'b0};
            mr_reg   <= '0;
            cnt_reg  <= MUL_LAST;
            dest_reg <= cmd.mul_dest;
        end else if (cmd.red_start) begin
            mx_reg   <= 30'd1;
            sh_reg   <= {raw_reg[62:0], 1'b0};
            mr_reg   <= raw_reg[63] ? (modulus - 30'd1) : '0;
            cnt_reg  <= RED_LAST;
            dest_reg <= MD_RES;
        end else if (cmd.div_start) begin
            dq_reg   <= er_reg;
            drem_reg <= '0;
            cnt_reg  <= DIV_LAST;
        end else if (cmd.mul_step) begin
            mr_reg  <= mr_next;
            sh_reg  <= {sh_reg[62:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                if (dest_reg == MD_BASE) begin
                    base_reg <= mr_next;
                end else begin
                    res_reg <= mr_next;
                end
            end
        end else if (cmd.div_step) begin
            drem_reg <= div_ge ? 30'(div_t - {1'b0, ea_reg}) : div_t[29:0];
            dq_reg   <= {dq_reg[28:0], div_ge};
            cnt_reg  <= cnt_reg - 6'd1;
        end
    end

    // Extended Euclid state
    always_ff @(posedge aclk) begin
        if (cmd.euc_init) begin
            er_reg <= modulus;
            ea_reg <= (func_reg == FN_INV) ? a_reg : b_reg;
            eu_reg <= 32'sd0;
            ev_reg <= 32'sd1;
        end
        if (cmd.emul) begin
            prod_reg <= 32'($signed({2'b00, dq_reg}) * ev_reg);
        end
        if (cmd.eupd) begin
            er_reg <= ea_reg;
            ea_reg <= drem_reg;
            eu_reg <= ev_reg;
            ev_reg <= eu_reg - prod_reg;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_result_reg <= res_reg;
            out_err_reg    <= err;
        end
    end

    always_comb begin
        sts.func     = func_reg;
        sts.err      = err;
        sts.mod_zero = (modulus == '0);
        sts.cnt_zero = (cnt_reg == '0);
        sts.e_zero   = (e_reg == '0);
        sts.e_lsb    = e_reg[0];
        sts.e_one    = (e_reg == 63'd1);
        sts.ea_zero  = (ea_reg == '0);
    end

    assign m_result      = out_result_reg;
    assign m_range_error = out_err_reg;

    `AMU_IMPLIES(a_err_zero_result, cmd.out_load && err, res_reg == '0,
                 "range error with nonzero result")

endmodule

// ===== design/amu_controller.sv =====
// Controller: sequences each operation and owns the output valid flag.
`include "assert_macros.svh"
module amu_controller
    import amu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  amu_sts_t sts,
    output amu_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_POW      = 11'b000_0000_0100,
        S_PSQ      = 11'b000_0000_1000,
        S_MUL      = 11'b000_0001_0000,
        S_ECHK     = 11'b000_0010_0000,
        S_DIV      = 11'b000_0100_0000,
        S_EMUL     = 11'b000_1000_0000,
        S_EUPD     = 11'b001_0000_0000,
        S_EFIX     = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.err || sts.mod_zero || (sts.func == FN_ADD) ||
                    (sts.func == FN_SUB) || (sts.func == FN_NEG)) begin
                    cmd.simple = 1'b1;
                    state_next = S_DONE;
                end else begin
                    case (sts.func)
                        FN_MUL: begin
                            cmd.mul_start = 1'b1;
                            cmd.mul_src   = MS_A_B;
                            cmd.mul_dest  = MD_RES;
                            ret_next      = S_DONE;
                            state_next    = S_MUL;
                        end
                        FN_REDUCE: begin
                            cmd.red_start = 1'b1;
                            ret_next      = S_DONE;
                            state_next    = S_MUL;
                        end
                        FN_POW: begin
                            cmd.pow_init = 1'b1;
                            state_next   = S_POW;
                        end
                        FN_INV, FN_DIV: begin
                            cmd.euc_init = 1'b1;
                            state_next   = S_ECHK;
                        end
                        default: begin
                            cmd.simple = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Square-and-multiply, exponent scanned from the low end
            S_POW: begin
                if (sts.e_zero) begin
                    state_next = S_DONE;
                end else if (sts.e_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_BASE_RES;
                    cmd.mul_dest  = MD_RES;
                    ret_next      = S_PSQ;
                    state_next    = S_MUL;
                end else begin
                    state_next = S_PSQ;
                end
            end
            S_PSQ: begin
                if (sts.e_one) begin
                    state_next = S_DONE;
                end else begin
                    cmd.e_shift   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_BASE_SQ;
                    cmd.mul_dest  = MD_BASE;
                    ret_next      = S_POW;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.cnt_zero) begin
                    state_next = ret_reg;
                end
            end
            // Extended Euclid rounds
            S_ECHK: begin
                if (sts.ea_zero) begin
                    state_next = S_EFIX;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.cnt_zero) begin
                    state_next = S_EMUL;
                end
            end
            S_EMUL: begin
                cmd.emul   = 1'b1;
                state_next = S_EUPD;
            end
            S_EUPD: begin
                cmd.eupd   = 1'b1;
                state_next = S_ECHK;
            end
            S_EFIX: begin
                cmd.efix = 1'b1;
                if (sts.func == FN_DIV) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_A_INV;
                    cmd.mul_dest  = MD_RES;
                    ret_next      = S_DONE;
                    state_next    = S_MUL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: set when a result is loaded, cleared when its beat is taken
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `AMU_IMPLIES(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready,
                 "result loaded over a pending beat")
    `AMU_NEXT(a_accept_dispatch, s_valid && s_ready, state_reg == S_DISPATCH,
              "accepted beat not dispatched")
    `AMU_IMPLIES(a_valid_drop, $fell(m_valid_reg), $past(m_ready),
                 "output valid dropped without a taken beat")

endmodule

// ===== design/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: APB register, controller and datapath.
//
// Input channel s_*: one beat carries func, two reduced operands, an exponent and a
// signed raw value. Result channel m_*: one beat per input beat with the result and
// a range flag. Both use valid/ready. The modulus is written over the APB port at
// byte address 0; the user must write it only while the unit is idle, as the unit
// does not enforce this. It resets to 998244353. One item is in work at a time.
// Steps from accept to result valid, by function:
//   add, sub, neg, or any range error: computed directly at dispatch
//   mul: one serial multiply; reduce: one remainder bit per cycle
//   pow: square-and-multiply over the exponent bits, on the serial multiplier
//   inv: up to about 45 Euclid rounds, each a serial divide; div: inv + multiply
// Multiplies run one bit of the multiplier per cycle through a shared modular
// Horner step; the Euclid quotient comes from a radix-2 restoring divider.
// A finished result sits in the output register; the next beat is accepted while
// it waits, and a new result holds in the controller until that slot is free.
// Reset (aresetn, synchronous) empties the output and returns the controller to idle.
module modular_arithmetic_unit
    import amu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [29:0] s_operand_a,
    input  logic [29:0] s_operand_b,
    input  logic [62:0] s_exponent,
    input  logic [63:0] s_raw_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [29:0] m_result,
    output logic        m_range_error
);

    logic [29:0] modulus_reg;
    amu_cmd_t    cmd;
    amu_sts_t    sts;

    // Modulus register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MODULUS)) begin
            modulus_reg <= pwdata[29:0];
        end
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? {2'b00, modulus_reg} : 32'd0;

    amu_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    amu_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .modulus       (modulus_reg),
        .s_func        (s_func),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .s_exponent    (s_exponent),
        .s_raw_value   (s_raw_value),
        .cmd           (cmd),
        .sts           (sts),
        .m_result      (m_result),
        .m_range_error (m_range_error)
    );

endmodule
